// ===== design/zsf_pkg.sv =====
// ----------------------------------------------------------------------------
// zsf_pkg
// Shared types and constants for the zlib stored-block framer.
// ----------------------------------------------------------------------------
package zsf_pkg;

  // Largest stored deflate block
  localparam int unsigned MAX_BLOCK = 65535;
  localparam int unsigned BLK_W     = 16;

  // Adler-32 modulus
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // zlib header bytes
  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;

  // Bound slack added to the worst-case length (zlib header plus trailer and more)
  localparam logic [32:0] BOUND_SLACK = 33'd19;

  // Configuration register indexes
  localparam logic CFG_STREAM_LENGTH   = 1'b0;
  localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

  // Input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Command queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Sequencer step counter width (up to ten bytes per command)
  localparam int unsigned STEP_W = 4;

  // Payload widths
  localparam int unsigned CNT_W = 33;

  typedef enum logic [1:0] {
    CMD_ERROR = 2'd0,
    CMD_HEAD  = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  // One classified input item, expanded into bytes by the back end
  typedef struct packed {
    cmd_kind_t         kind;
    logic              hdr;    // data: block header goes first
    logic              trail;  // Adler-32 trailer follows
    logic              fin;    // block header: final flag
    logic [BLK_W-1:0]  blk;    // block header: LEN
    logic [7:0]        data;   // data: source byte
    logic [31:0]       adler;  // trailer value
  } cmd_t;

endpackage

// ===== design/zsf_front.sv =====
// ----------------------------------------------------------------------------
// zsf_front
// Accepts input beats, tracks stream and block state, runs the Adler-32
// sums and pushes one command per result-bearing beat into the queue.
// ----------------------------------------------------------------------------
module zsf_front (
  input  logic                 clk,
  input  logic                 rst,
  // config
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  // input beat
  input  logic                 in_fire,
  input  logic                 in_op,
  input  logic [7:0]           in_byte,
  // queue push
  output logic                 push,
  output zsf_pkg::cmd_t        push_cmd
);

  logic [31:0]               stream_length;
  logic [31:0]               output_capacity;
  logic [32:0]               bound;
  logic [31:0]               bytes_left;
  logic [zsf_pkg::BLK_W-1:0] block_left;
  logic [15:0]               sum_low;
  logic [15:0]               sum_high;
  logic                      active;

  logic [32:0]               bound_new;
  logic [zsf_pkg::BLK_W-1:0] blk;
  logic                      blk_full;
  logic [16:0]               low_add;
  logic [15:0]               low_new;
  logic [16:0]               high_add;
  logic [15:0]               high_new;
  logic                      last_byte;
  logic                      fail;

  // Worst-case output bound, worked out when the length is written
  assign bound_new = {1'b0, cfg_data} + {13'd0, cfg_data[31:12]}
                   + {15'd0, cfg_data[31:14]} + {26'd0, cfg_data[31:25]}
                   + zsf_pkg::BOUND_SLACK;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length   <= '0;
      output_capacity <= '0;
      bound           <= zsf_pkg::BOUND_SLACK;
    end else if (cfg_we) begin
      if (cfg_index == zsf_pkg::CFG_STREAM_LENGTH) begin
        stream_length <= cfg_data;
        bound         <= bound_new;
      end else if (cfg_index == zsf_pkg::CFG_OUTPUT_CAPACITY) begin
        output_capacity <= cfg_data;
      end
    end
  end

  // Block length and Adler update for a data byte
  assign blk_full  = bytes_left > 32'(zsf_pkg::MAX_BLOCK);
  assign blk       = blk_full ? zsf_pkg::BLK_W'(zsf_pkg::MAX_BLOCK)
                              : bytes_left[zsf_pkg::BLK_W-1:0];
  assign low_add   = {1'b0, sum_low} + {9'd0, in_byte};
  assign low_new   = (low_add >= zsf_pkg::ADLER_MOD) ? 16'(low_add - zsf_pkg::ADLER_MOD)
                                                     : low_add[15:0];
  assign high_add  = {1'b0, sum_high} + {1'b0, low_new};
  assign high_new  = (high_add >= zsf_pkg::ADLER_MOD) ? 16'(high_add - zsf_pkg::ADLER_MOD)
                                                      : high_add[15:0];
  assign last_byte = bytes_left == 32'd1;
  assign fail      = {1'b0, output_capacity} < bound;

  // Command build
  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    if (in_fire) begin
      if (in_op == zsf_pkg::OP_START) begin
        push           = 1'b1;
        push_cmd.kind  = fail ? zsf_pkg::CMD_ERROR : zsf_pkg::CMD_HEAD;
        push_cmd.trail = !fail && (stream_length == 32'd0);
        push_cmd.adler = 32'd1;
      end else if (active) begin
        push           = 1'b1;
        push_cmd.kind  = zsf_pkg::CMD_DATA;
        push_cmd.hdr   = block_left == '0;
        push_cmd.trail = last_byte;
        push_cmd.fin   = !blk_full;
        push_cmd.blk   = blk;
        push_cmd.data  = in_byte;
        push_cmd.adler = {high_new, low_new};
      end
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      block_left <= '0;
      sum_low    <= 16'd1;
      sum_high   <= '0;
      active     <= 1'b0;
    end else if (in_fire) begin
      if (in_op == zsf_pkg::OP_START) begin
        bytes_left <= stream_length;
        block_left <= '0;
        sum_low    <= 16'd1;
        sum_high   <= '0;
        active     <= !fail && (stream_length != 32'd0);
      end else if (active) begin
        bytes_left <= bytes_left - 32'd1;
        block_left <= ((block_left == '0) ? blk : block_left) - zsf_pkg::BLK_W'(1);
        sum_low    <= low_new;
        sum_high   <= high_new;
        active     <= !last_byte;
      end
    end
  end

endmodule

// ===== design/zsf_queue.sv =====
// ----------------------------------------------------------------------------
// zsf_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module zsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  zsf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output zsf_pkg::cmd_t head_cmd
);

  zsf_pkg::cmd_t               mem [zsf_pkg::QDEPTH];
  logic [zsf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [zsf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [zsf_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full       = count == zsf_pkg::QCNT_W'(zsf_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + zsf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + zsf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + zsf_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - zsf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/zsf_back.sv =====
// ----------------------------------------------------------------------------
// zsf_back
// Expands the head command into output bytes, one per cycle while the output
// is not stalled, keeps the running byte count and holds the output register.
// ----------------------------------------------------------------------------
module zsf_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  zsf_pkg::cmd_t              head_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_status,
  output logic                       out_run_end,
  output logic                       out_stream_end,
  output logic [zsf_pkg::CNT_W-1:0]  out_total
);

  logic [zsf_pkg::STEP_W-1:0] step;
  logic [zsf_pkg::CNT_W-1:0]  written_count;

  logic                       load;
  logic [zsf_pkg::STEP_W-1:0] len_a;
  logic [zsf_pkg::STEP_W-1:0] len_ab;
  logic [zsf_pkg::STEP_W-1:0] total;
  logic [zsf_pkg::STEP_W-1:0] t_idx;
  logic                       last;
  logic [7:0]                 byte_sel;
  logic [zsf_pkg::CNT_W-1:0]  count_sel;
  logic                       is_error;

  assign load     = head_valid && (!out_valid || out_ready);
  assign is_error = head_cmd.kind == zsf_pkg::CMD_ERROR;

  // Segment lengths: lead bytes, data byte, trailer
  always_comb begin
    len_a  = '0;
    len_ab = '0;
    case (head_cmd.kind)
      zsf_pkg::CMD_HEAD: begin
        len_a  = zsf_pkg::STEP_W'(2);
        len_ab = zsf_pkg::STEP_W'(2);
      end
      zsf_pkg::CMD_DATA: begin
        len_a  = head_cmd.hdr ? zsf_pkg::STEP_W'(5) : '0;
        len_ab = len_a + zsf_pkg::STEP_W'(1);
      end
      default: begin
        len_a  = zsf_pkg::STEP_W'(1);
        len_ab = zsf_pkg::STEP_W'(1);
      end
    endcase
    total = len_ab + (head_cmd.trail ? zsf_pkg::STEP_W'(4) : '0);
    t_idx = step - len_ab;
    last  = step == total - zsf_pkg::STEP_W'(1);
  end

  // Byte select for the current step
  always_comb begin
    byte_sel = '0;
    if (is_error) begin
      byte_sel = '0;
    end else if (step < len_a) begin
      if (head_cmd.kind == zsf_pkg::CMD_HEAD) begin
        byte_sel = (step == '0) ? zsf_pkg::ZLIB_CMF : zsf_pkg::ZLIB_FLG;
      end else begin
        case (step[2:0])
          3'd0:    byte_sel = {7'd0, head_cmd.fin};
          3'd1:    byte_sel = head_cmd.blk[7:0];
          3'd2:    byte_sel = head_cmd.blk[15:8];
          3'd3:    byte_sel = ~head_cmd.blk[7:0];
          default: byte_sel = ~head_cmd.blk[15:8];
        endcase
      end
    end else if (step < len_ab) begin
      byte_sel = head_cmd.data;
    end else begin
      case (t_idx[1:0])
        2'd0:    byte_sel = head_cmd.adler[31:24];
        2'd1:    byte_sel = head_cmd.adler[23:16];
        2'd2:    byte_sel = head_cmd.adler[15:8];
        default: byte_sel = head_cmd.adler[7:0];
      endcase
    end
  end

  // A start restarts the byte count; an error reports zero
  always_comb begin
    if (is_error) begin
      count_sel = '0;
    end else if (head_cmd.kind == zsf_pkg::CMD_HEAD && step == '0) begin
      count_sel = zsf_pkg::CNT_W'(1);
    end else begin
      count_sel = written_count + zsf_pkg::CNT_W'(1);
    end
  end

  assign pop = load && last;

  // Step counter and running count
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= '0;
      written_count <= '0;
    end else if (load) begin
      step          <= last ? '0 : step + zsf_pkg::STEP_W'(1);
      written_count <= count_sel;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= byte_sel;
      out_status     <= is_error;
      out_run_end    <= last;
      out_stream_end <= is_error || (last && head_cmd.trail);
      out_total      <= count_sel;
    end
  end

endmodule

// ===== design/zlib_stored_block_framer.sv =====
// ----------------------------------------------------------------------------
// zlib_stored_block_framer
// Wraps a byte stream in a zlib container of stored deflate blocks with an
// Adler-32 trailer; checks the output capacity against the worst-case bound.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tuser                | tlast
//  s_*      | in  | [7:0] data_byte                        | [0] op               | -
//  m_*      | out | [7:0] out_byte, [40:8] total_bytes     | [0] status,          | run_end
//           |     |                                        | [1] stream_end       |
//  cfg_*    | in  | cfg_index 0 stream_length, 1 output_capacity, cfg_data 32 bits
//
//  One output beat per cycle from the back-end sequencer while m_tready holds:
//  a data beat yields one byte, plus five for a block header and four for the
//  trailer; a start yields two (six for an empty stream, one on error).
//  Input beats are taken every cycle while the four-entry command queue has room.
//  Reset (rst, synchronous) clears the queue, the stream state and the output.
//  Output stalls back up through the queue to s_tready only.
// ----------------------------------------------------------------------------
module zlib_stored_block_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_byte, [40:8] total_bytes, zero pad
  output logic [1:0]  m_tuser,   // [0] status, [1] stream_end
  output logic        m_tlast    // run_end
);

  logic                       in_fire;
  logic                       push;
  zsf_pkg::cmd_t              push_cmd;
  logic                       full;
  logic                       pop;
  logic                       head_valid;
  zsf_pkg::cmd_t              head_cmd;
  logic [7:0]                 out_byte;
  logic                       out_status;
  logic                       out_stream_end;
  logic [zsf_pkg::CNT_W-1:0]  out_total;

  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;

  // Front end: classify beats
  zsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_op     (s_tuser[0]),
    .in_byte   (s_tdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue
  zsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: byte sequencer
  zsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_run_end    (m_tlast),
    .out_stream_end (out_stream_end),
    .out_total      (out_total)
  );

  assign m_tdata = {7'd0, out_total, out_byte};
  assign m_tuser = {out_stream_end, out_status};

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zlib stored-block framer: a tracker class follows
// the zlib framing, stored-block headers and Adler-32 of every accepted source
// beat and matches each output beat field by field. Directed streams hit the
// capacity bound edges, empty and aborted streams; random streams follow, one
// of them sent with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT   = 2000;  // cycles with no beat in either direction
  localparam int SETTLE_CYCLES = 48;    // above queue depth times the longest expansion
  localparam int IDLE_PCT      = 36;

  typedef struct {
    logic [7:0]  out_byte;
    logic        status;
    logic        run_end;
    logic        stream_end;
    logic [32:0] total_bytes;
  } zlib_beat_t;

  // Follows the framer state and holds the output beats still due
  class zlib_frame_tracker;
    logic [31:0] len_reg;
    logic [31:0] cap_reg;
    logic [31:0] src_left;
    logic [15:0] blk_left;
    logic [15:0] adler_a;
    logic [15:0] adler_b;
    logic [32:0] written;
    logic        in_stream;
    zlib_beat_t  beats_due[$];
    zlib_beat_t  run_buf[10];
    int          run_n;
    int          mismatches;

    function new();
      len_reg    = '0;
      cap_reg    = '0;
      src_left   = '0;
      blk_left   = '0;
      adler_a    = 16'd1;
      adler_b    = '0;
      written    = '0;
      in_stream  = 1'b0;
      mismatches = 0;
    endfunction

    // Worst-case zlib size for a stream of len bytes, no overflow
    function logic [63:0] min_capacity(logic [31:0] len);
      logic [63:0] l;
      l = {32'd0, len};
      return l + (l >> 12) + (l >> 14) + (l >> 25) + 64'd19;
    endfunction

    function int due();
      return beats_due.size();
    endfunction

    function void put(logic [7:0] b);
      written                     = written + 33'd1;
      run_buf[run_n].out_byte     = b;
      run_buf[run_n].status       = 1'b0;
      run_buf[run_n].run_end      = 1'b0;
      run_buf[run_n].stream_end   = 1'b0;
      run_buf[run_n].total_bytes  = written;
      run_n++;
    endfunction

    function void put_adler();
      put(adler_b[15:8]);
      put(adler_b[7:0]);
      put(adler_a[15:8]);
      put(adler_a[7:0]);
      run_buf[run_n-1].stream_end = 1'b1;
      in_stream = 1'b0;
    endfunction

    // One accepted source beat; returns the number of output beats it causes
    function int note_item(logic op, logic [7:0] b);
      logic [15:0] blk;
      logic [16:0] sum;
      run_n = 0;
      if (op == zsf_pkg::OP_START) begin
        src_left = len_reg;
        blk_left = '0;
        adler_a  = 16'd1;
        adler_b  = '0;
        written  = '0;
        if ({32'd0, cap_reg} < min_capacity(len_reg)) begin
          in_stream                  = 1'b0;
          run_buf[0].out_byte        = 8'h00;
          run_buf[0].status          = 1'b1;
          run_buf[0].stream_end      = 1'b1;
          run_buf[0].total_bytes     = '0;
          run_n                      = 1;
        end else begin
          in_stream = 1'b1;
          put(zsf_pkg::ZLIB_CMF);
          put(zsf_pkg::ZLIB_FLG);
          if (src_left == 0) put_adler();
        end
      end else if (in_stream) begin
        // stored block header ahead of the first byte of each block
        if (blk_left == 0) begin
          blk = (src_left > zsf_pkg::MAX_BLOCK) ? 16'(zsf_pkg::MAX_BLOCK) : src_left[15:0];
          put((src_left == {16'd0, blk}) ? 8'h01 : 8'h00);
          put(blk[7:0]);
          put(blk[15:8]);
          put(~blk[7:0]);
          put(~blk[15:8]);
          blk_left = blk;
        end
        put(b);
        sum = {1'b0, adler_a} + {9'd0, b};
        if (sum >= zsf_pkg::ADLER_MOD) sum = sum - zsf_pkg::ADLER_MOD;
        adler_a = sum[15:0];
        sum = {1'b0, adler_b} + {1'b0, adler_a};
        if (sum >= zsf_pkg::ADLER_MOD) sum = sum - zsf_pkg::ADLER_MOD;
        adler_b  = sum[15:0];
        blk_left = blk_left - 16'd1;
        src_left = src_left - 32'd1;
        if (src_left == 0) put_adler();
      end
      if (run_n > 0) begin
        run_buf[run_n-1].run_end = 1'b1;
        for (int i = 0; i < run_n; i++) beats_due.push_back(run_buf[i]);
      end
      return run_n;
    endfunction

    // One accepted output beat against the oldest beat due
    function void check_beat(logic [7:0] ob, logic st, logic re, logic se, logic [32:0] tb);
      zlib_beat_t e;
      if (beats_due.size() == 0) begin
        $error("output beat with nothing due: out_byte %0h total_bytes %0d", ob, tb);
        mismatches++;
        return;
      end
      e = beats_due.pop_front();
      if (ob !== e.out_byte) begin
        $error("out_byte expected %0h got %0h", e.out_byte, ob);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status expected %0h got %0h", e.status, st);
        mismatches++;
      end
      if (re !== e.run_end) begin
        $error("run_end expected %0h got %0h", e.run_end, re);
        mismatches++;
      end
      if (se !== e.stream_end) begin
        $error("stream_end expected %0h got %0h", e.stream_end, se);
        mismatches++;
      end
      if (tb !== e.total_bytes) begin
        $error("total_bytes expected %0d got %0d", e.total_bytes, tb);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = zsf_pkg::CFG_STREAM_LENGTH;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic [0:0]  s_tuser = '0;   // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [7:0] out_byte, [40:8] total_bytes, zero pad
  logic [1:0]  m_tuser;        // [0] status, [1] stream_end
  logic        m_tlast;        // run_end

  zlib_frame_tracker tracker;
  bit  calm = 1'b0;
  int  items_sent;
  int  stall_cycles;

  zlib_stored_block_framer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sink back-pressure
  always @(posedge clk) begin
    if (calm) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Output monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (m_tvalid && m_tready)
        tracker.check_beat(m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[1], m_tdata[40:8]);
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[zlib_stored_block_framer] ERROR");
        $finish;
      end
    end
  end

  // One source beat, with a random gap ahead of it
  task automatic send_beat(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    void'(tracker.note_item(op, b));
    items_sent++;
  endtask

  task automatic send_bytes(input int n);
    for (int i = 0; i < n; i++) send_beat(zsf_pkg::OP_DATA, 8'($urandom));
  endtask

  // Stop the source and let every due beat drain out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.due() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, one after the other, with the block drained
  task automatic set_regs(input logic [31:0] len, input logic [31:0] cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= zsf_pkg::CFG_STREAM_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= zsf_pkg::CFG_OUTPUT_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.len_reg = len;
    tracker.cap_reg = cap;
  endtask

  // Capacity at, just below or up to 100 above the bound, or anything at all
  function automatic logic [31:0] pick_capacity(logic [31:0] len);
    logic [63:0] bnd;
    logic [63:0] cap;
    int          mode;
    bnd  = tracker.min_capacity(len);
    mode = $urandom_range(0, 99);
    if (mode < 60) cap = bnd + 64'($urandom_range(0, 100));
    else if (mode < 75) cap = bnd;
    else if (mode < 90) cap = bnd - 64'd1;
    else cap = {32'd0, $urandom};
    return (cap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cap[31:0];
  endfunction

  initial begin
    logic [31:0] len;
    int          mode;
    int          nsend;
    int          phase;
    tracker      = new();
    items_sent   = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty stream: header and trailer only
    set_regs(32'd0, 32'd19);
    send_beat(zsf_pkg::OP_START, 8'h00);
    // capacity one short of the bound, then data while idle
    set_regs(32'd0, 32'd18);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'hFF);
    // both registers at full scale: bound exceeds 32 bits
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(zsf_pkg::OP_START, 8'hFF);
    send_beat(zsf_pkg::OP_DATA, 8'h00);
    // capacity exactly at the bound, extreme bytes, data after the end
    set_regs(32'd3, 32'd22);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'hFF);
    send_beat(zsf_pkg::OP_DATA, 8'h5A);
    send_beat(zsf_pkg::OP_DATA, 8'h11);
    set_regs(32'd3, 32'd21);
    send_beat(zsf_pkg::OP_START, 8'h00);
    // huge stream: non-final block header, then restart while active
    set_regs(32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'hFF);
    send_beat(zsf_pkg::OP_DATA, 8'h00);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'hA5);
    set_regs(32'd2, 32'hFFFF_FFFF);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'hAB);
    send_beat(zsf_pkg::OP_DATA, 8'hCD);
    set_regs(32'd1, 32'd0);
    send_beat(zsf_pkg::OP_START, 8'h00);
    set_regs(32'd1, 32'd20);
    send_beat(zsf_pkg::OP_START, 8'h00);
    send_beat(zsf_pkg::OP_DATA, 8'h7F);

    // random streams: mostly complete, some cut short or followed by noise;
    // one full stream goes through with no idling on either side
    phase = 0;
    while (items_sent < 140) begin
      mode = $urandom_range(0, 99);
      if (phase == 4) len = 32'd48;
      else if (mode < 70) len = $urandom_range(0, 12);
      else if (mode < 85) len = $urandom_range(13, 24);
      else len = $urandom;
      set_regs(len, (phase == 4) ? 32'hFFFF_FFFF : pick_capacity(len));
      calm = (phase == 4);
      send_beat(zsf_pkg::OP_START, 8'($urandom));
      mode = $urandom_range(0, 99);
      if (phase == 4) nsend = len;
      else if (len > 24) nsend = $urandom_range(0, 4);
      else if (mode < 75) nsend = len;
      else if (mode < 90) nsend = $urandom_range(0, len);
      else nsend = len + $urandom_range(1, 3);
      send_bytes(nsend);
      calm = 1'b0;
      phase++;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("[zlib_stored_block_framer] OK");
    end else begin
      $display("[zlib_stored_block_framer] ERROR");
    end
    $finish;
  end
endmodule
